>>> src/ttcg_pkg.sv
// ----------------------------------------------------------------------------
// ttcg_pkg
// Shared types and constants of the text tile character generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcg_pkg;

  localparam int GRID_COLS  = 40;
  localparam int GRID_ROWS  = 30;
  localparam int TILE_DEPTH = GRID_COLS * GRID_ROWS;
  localparam int TILE_AW    = $clog2(TILE_DEPTH);
  localparam int GLYPH_H    = 8;
  localparam int CODE_W     = 8;
  localparam int LINE_W     = 3;
  localparam int FONT_DEPTH = (1 << CODE_W) * GLYPH_H;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int COLOR_W    = 8;
  localparam int CUR_W      = 9;
  localparam int GRID_IW    = 7;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 8;
  localparam int IN_DW      = 56;
  localparam int IN_UW      = 2;
  localparam int OUT_DW     = 8;
  localparam int OUT_UW     = 1;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [IN_UW-1:0] {
    OP_FONT   = 2'd0,
    OP_ORIGIN = 2'd1,
    OP_CHAR   = 2'd2,
    OP_PIXEL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_FORE  = 2'd0,
    CFG_BACK  = 2'd1,
    CFG_SEE   = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic               we;
    logic [TILE_AW-1:0] addr;
    logic [CODE_W-1:0]  data;
  } tile_wr_t;

  typedef struct packed {
    logic               re;
    logic [TILE_AW-1:0] addr;
  } tile_rd_t;

  typedef struct packed {
    logic               re;
    logic [FONT_AW-1:0] addr;
  } font_rd_t;

endpackage

`default_nettype wire

>>> src/text_tile_character_generator_top.sv
// ----------------------------------------------------------------------------
// text_tile_character_generator_top
// Text-mode character generator with a tile map and a loadable 8x8 font.
//
// in_tuser carries the opcode: font row load, text origin, text character,
// or pixel render. Only a render produces a transfer on the out_ channel:
// out_tdata is the color, out_tuser is 1 when the pixel is drawn.
// One item is taken per clock while in_tready is high. A render result passes
// through the tile map RAM read at the input transfer edge, the font RAM read
// and the output register load, in that order, before out_tvalid rises; a
// stall on out_tready can hold it in any of these stages.
// Loads and text items finish in the cycle they are taken.
// After reset the tile map is swept to zero, one entry per cycle, over all
// 1200 entries (GRID_COLS * GRID_ROWS); in_tready stays low meanwhile while
// cfg_ writes are still taken. Font rows are undefined until loaded.
// When out_tready is low, the pipeline keeps filling its empty stages and
// deasserts in_tready only once the result and both RAM stages are held.
// ----------------------------------------------------------------------------
`default_nettype none

module text_tile_character_generator_top
  import ttcg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // [7:0] char_code, [10:8] glyph_line, [18:11] line_bits, [26:19] text_col,
  // [34:27] text_row, [43:35] pixel_x, [51:44] pixel_y, [55:52] zero
  input  wire logic [IN_DW-1:0]   in_tdata,
  // [1:0] opcode
  input  wire logic [IN_UW-1:0]   in_tuser,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [7:0] pixel_color
  output logic [OUT_DW-1:0]       out_tdata,
  // [0] pixel_drawn
  output logic [OUT_UW-1:0]       out_tuser,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [CFG_DW-1:0]  cfg_wdata
);

  op_t                opcode;
  logic [CODE_W-1:0]  char_code;
  logic [LINE_W-1:0]  glyph_line;
  logic [7:0]         line_bits;
  logic signed [7:0]  text_col;
  logic signed [7:0]  text_row;
  logic [8:0]         pixel_x;
  logic [7:0]         pixel_y;
  logic               in_fire;
  logic               take;

  logic [COLOR_W-1:0] fore_r, back_r;
  logic               see_r;

  logic               clr_r, clr_nxt;
  logic [TILE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  tile_wr_t           cur_wr;
  tile_rd_t           tile_rd;
  font_rd_t           font_rd;
  logic               tile_we;
  logic [TILE_AW-1:0] tile_waddr;
  logic [CODE_W-1:0]  tile_wdata;
  logic [CODE_W-1:0]  tile_rdata;
  logic [7:0]         font_rdata;
  logic               font_we;

  assign opcode     = op_t'(in_tuser);
  assign char_code  = in_tdata[7:0];
  assign glyph_line = in_tdata[10:8];
  assign line_bits  = in_tdata[18:11];
  assign text_col   = in_tdata[26:19];
  assign text_row   = in_tdata[34:27];
  assign pixel_x    = in_tdata[43:35];
  assign pixel_y    = in_tdata[51:44];

  assign in_tready = take && !clr_r;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= 8'd255;
      back_r <= 8'd0;
      see_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FORE:  fore_r <= cfg_wdata;
        CFG_BACK:  back_r <= cfg_wdata;
        CFG_SEE:   see_r  <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + TILE_AW'(1);
      if (clr_cnt_r == TILE_AW'(TILE_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  ttcg_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .opcode    (opcode),
    .char_code (char_code),
    .text_col  (text_col),
    .text_row  (text_row),
    .tile_wr   (cur_wr)
  );

  assign tile_we    = clr_r || cur_wr.we;
  assign tile_waddr = clr_r ? clr_cnt_r : cur_wr.addr;
  assign tile_wdata = clr_r ? '0 : cur_wr.data;

  ttcg_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TILE_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .re    (tile_rd.re),
    .raddr (tile_rd.addr),
    .rdata (tile_rdata)
  );

  assign font_we = in_fire && (opcode == OP_FONT);

  ttcg_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr ({char_code, glyph_line}),
    .wdata (line_bits),
    .re    (font_rd.re),
    .raddr (font_rd.addr),
    .rdata (font_rdata)
  );

  ttcg_render u_render (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire && (opcode == OP_PIXEL)),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .tile_rdata  (tile_rdata),
    .font_rdata  (font_rdata),
    .fore_color  (fore_r),
    .back_color  (back_r),
    .see_through (see_r),
    .out_tready  (out_tready),
    .take        (take),
    .tile_rd     (tile_rd),
    .font_rd     (font_rd),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

>>> src/ttcg_ram.sv
// ----------------------------------------------------------------------------
// ttcg_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/ttcg_cursor.sv
// ----------------------------------------------------------------------------
// ttcg_cursor
// Text cursor: origin and cursor registers, newline and stop handling, and
// the tile map write for each character that lands in the grid while not stopped.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcg_cursor
  import ttcg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire op_t               opcode,
  input  wire logic [CODE_W-1:0] char_code,
  input  wire logic signed [7:0] text_col,
  input  wire logic signed [7:0] text_row,
  output tile_wr_t               tile_wr
);

  logic signed [CUR_W-1:0] col_r, col_nxt;
  logic signed [CUR_W-1:0] row_r, row_nxt;
  logic signed [CUR_W-1:0] org_r, org_nxt;
  logic                    stop_r, stop_nxt;
  logic                    in_grid;
  logic                    char_fire;
  logic signed [CUR_W-1:0] row_inc;

  assign in_grid = (col_r >= 0) && (col_r < $signed(CUR_W'(GRID_COLS))) &&
                   (row_r >= 0) && (row_r < $signed(CUR_W'(GRID_ROWS)));
  assign char_fire = fire && (opcode == OP_CHAR) && !stop_r;
  assign row_inc   = row_r + CUR_W'(1);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    org_nxt  = org_r;
    stop_nxt = stop_r;
    tile_wr.we   = 1'b0;
    tile_wr.addr = TILE_AW'(TILE_AW'(row_r[GRID_IW-1:0]) * TILE_AW'(GRID_COLS) +
                            TILE_AW'(col_r[GRID_IW-1:0]));
    tile_wr.data = char_code;
    if (fire && (opcode == OP_ORIGIN)) begin
      org_nxt  = CUR_W'(text_col);
      col_nxt  = CUR_W'(text_col);
      row_nxt  = CUR_W'(text_row);
      stop_nxt = 1'b0;
    end else if (char_fire) begin
      priority if (char_code == '0) begin
        stop_nxt = 1'b1;
      end else if (char_code == NEWLINE_CODE) begin
        col_nxt = org_r;
        row_nxt = row_inc;
        if (row_inc >= $signed(CUR_W'(GRID_ROWS))) begin
          stop_nxt = 1'b1;
        end
      end else if (in_grid) begin
        tile_wr.we = 1'b1;
        col_nxt    = col_r + CUR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      org_r  <= '0;
      stop_r <= 1'b1;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      org_r  <= org_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/ttcg_render.sv
// ----------------------------------------------------------------------------
// ttcg_render
// Pixel pipeline: tile map read, font read, bit select into the output
// register, with per-stage stall so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcg_render
  import ttcg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic [8:0]         pixel_x,
  input  wire logic [7:0]         pixel_y,
  input  wire logic [CODE_W-1:0]  tile_rdata,
  input  wire logic [7:0]         font_rdata,
  input  wire logic [COLOR_W-1:0] fore_color,
  input  wire logic [COLOR_W-1:0] back_color,
  input  wire logic               see_through,
  input  wire logic               out_tready,
  output logic                    take,
  output tile_rd_t                tile_rd,
  output font_rd_t                font_rd,
  output logic                    out_tvalid,
  output logic [OUT_DW-1:0]       out_tdata,
  output logic [OUT_UW-1:0]       out_tuser
);

  logic               en_out, en_c, en_b;
  logic [5:0]         tx;
  logic [4:0]         ty;
  logic               off_grid;
  logic               b_v_r, b_off_r;
  logic [LINE_W-1:0]  b_line_r, b_bit_r;
  logic               c_v_r, c_blank_r;
  logic [LINE_W-1:0]  c_bit_r;
  logic               o_v_r;
  logic [COLOR_W-1:0] o_color_r, o_color_nxt;
  logic               o_drawn_r, o_drawn_nxt;
  logic               pix_set;

  assign en_out = !o_v_r || out_tready;
  assign en_c   = !c_v_r || en_out;
  assign en_b   = !b_v_r || en_c;
  assign take   = en_b;

  assign tx       = pixel_x[8:3];
  assign ty       = pixel_y[7:3];
  assign off_grid = (7'(tx) >= 7'(GRID_COLS)) || (7'(ty) >= 7'(GRID_ROWS));

  assign tile_rd.re   = en_b;
  assign tile_rd.addr = TILE_AW'(TILE_AW'(ty) * TILE_AW'(GRID_COLS) + TILE_AW'(tx));

  assign font_rd.re   = en_c;
  assign font_rd.addr = {tile_rdata, b_line_r};

  assign pix_set = font_rdata[LINE_W'(7) - c_bit_r];

  always_comb begin
    o_color_nxt = '0;
    o_drawn_nxt = 1'b0;
    if (!c_blank_r) begin
      if (pix_set) begin
        o_color_nxt = fore_color;
        o_drawn_nxt = 1'b1;
      end else if (!see_through) begin
        o_color_nxt = back_color;
        o_drawn_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (en_b) begin
        b_v_r <= fire;
      end
      if (en_c) begin
        c_v_r <= b_v_r;
      end
      if (en_out) begin
        o_v_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_off_r  <= off_grid;
      b_line_r <= pixel_y[LINE_W-1:0];
      b_bit_r  <= pixel_x[LINE_W-1:0];
    end
    if (en_c) begin
      c_blank_r <= b_off_r || (tile_rdata == '0);
      c_bit_r   <= b_bit_r;
    end
    if (en_out) begin
      o_color_r <= o_color_nxt;
      o_drawn_r <= o_drawn_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_color_r;
  assign out_tuser  = o_drawn_r;

endmodule

`default_nettype wire
